/* design/scfbc_pkg.sv */
// ----------------------------------------------------------------------------
// scfbc_pkg
// Shared types, sizes and helpers for the size class free block cache.
// ----------------------------------------------------------------------------
`default_nettype none

package scfbc_pkg;

    // table geometry
    localparam int SLOTS_PER_CLASS = 32;
    localparam int HEAP_COUNT      = 2;
    localparam int CLASS_COUNT     = 11;

    // field widths
    localparam int WORD_W    = 24;
    localparam int CNT_W     = 32;
    localparam int SLOT_BITS = 1 + 2 * WORD_W;
    localparam int ROW_BITS  = SLOTS_PER_CLASS * SLOT_BITS;
    localparam int ROW_COUNT = HEAP_COUNT * CLASS_COUNT;
    localparam int ROW_W     = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int CLASS_W   = 4;
    localparam int SLOT_W    = (SLOTS_PER_CLASS > 1) ? $clog2(SLOTS_PER_CLASS) : 1;

    // best fit search runs in groups of slots, then across the groups
    localparam int GROUP_SIZE  = 8;
    localparam int GROUP_COUNT = (SLOTS_PER_CLASS + GROUP_SIZE - 1) / GROUP_SIZE;

    typedef enum logic [1:0] {
        MODE_GET    = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_FLUSH  = 2'd3
    } t_mode;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd;
        logic srch1;
        logic srch2;
        logic next_class;
        logic write;
        logic flush;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic bad_heap;
        logic flush;
        logic zero_words;
        logic is_get;
        logic hit;
        logic last_class;
    } t_status;

    // size class of a block size in words
    function automatic logic [CLASS_W-1:0] size_class(input logic [WORD_W-1:0] w);
        logic [CLASS_W-1:0] c;
        if (w < WORD_W'(8))          c = CLASS_W'(0);
        else if (w < WORD_W'(16))    c = CLASS_W'(1);
        else if (w < WORD_W'(32))    c = CLASS_W'(2);
        else if (w < WORD_W'(64))    c = CLASS_W'(3);
        else if (w < WORD_W'(128))   c = CLASS_W'(4);
        else if (w < WORD_W'(256))   c = CLASS_W'(5);
        else if (w < WORD_W'(512))   c = CLASS_W'(6);
        else if (w < WORD_W'(1024))  c = CLASS_W'(7);
        else if (w < WORD_W'(4096))  c = CLASS_W'(8);
        else if (w < WORD_W'(8192))  c = CLASS_W'(9);
        else                         c = CLASS_W'(10);
        return c;
    endfunction

endpackage

`default_nettype wire

/* design/scfbc_ram.sv */
// ----------------------------------------------------------------------------
// scfbc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module scfbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* design/scfbc_dp.sv */
// ----------------------------------------------------------------------------
// scfbc_dp
// Datapath: request registers, slot table RAM, best fit and slot search,
// row write-back, hit counters and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module scfbc_dp import scfbc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    output t_status                o_status,
    input  wire logic [1:0]        i_mode,
    input  wire logic              i_heap_select,
    input  wire logic [WORD_W-1:0] i_block_addr,
    input  wire logic [WORD_W-1:0] i_block_words,
    output logic                   o_ok,
    output logic [WORD_W-1:0]      o_found_addr,
    output logic [WORD_W-1:0]      o_found_words,
    output logic [CNT_W-1:0]       o_take_count
);

    // request registers
    t_mode               r_mode;
    logic                r_heap;
    logic [WORD_W-1:0]   r_addr;
    logic [WORD_W-1:0]   r_words;
    logic [CLASS_W-1:0]  r_class;

    // search and result registers
    logic                r_grp_hit   [GROUP_COUNT];
    logic [WORD_W-1:0]   r_grp_words [GROUP_COUNT];
    logic [SLOT_W-1:0]   r_grp_idx   [GROUP_COUNT];
    logic                r_hit;
    logic [SLOT_W-1:0]   r_slot;
    logic                r_ok;
    logic [WORD_W-1:0]   r_faddr;
    logic [WORD_W-1:0]   r_fwords;
    logic [CNT_W-1:0]    r_cnt [HEAP_COUNT];
    logic [ROW_COUNT-1:0] r_row_vld;

    logic                heap_ok;
    logic [ROW_W-1:0]    row;
    logic [ROW_BITS-1:0] rd_row;
    logic [ROW_BITS-1:0] wr_row;
    logic [SLOTS_PER_CLASS-1:0] s_vld;
    logic [WORD_W-1:0]   s_addr  [SLOTS_PER_CLASS];
    logic [WORD_W-1:0]   s_words [SLOTS_PER_CLASS];

    logic                g_hit   [GROUP_COUNT];
    logic [WORD_W-1:0]   g_words [GROUP_COUNT];
    logic [SLOT_W-1:0]   g_idx   [GROUP_COUNT];
    logic                p_hit;
    logic [SLOT_W-1:0]   p_idx;
    logic                f_hit;
    logic [WORD_W-1:0]   f_words;
    logic [SLOT_W-1:0]   f_idx;

    assign heap_ok = (32'(r_heap) < HEAP_COUNT);
    assign row     = ROW_W'(32'(r_heap) * CLASS_COUNT + 32'(r_class));

    // slot table, one class row per word
    scfbc_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (ROW_COUNT)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.write),
        .i_wr_addr (row),
        .i_wr_data (wr_row),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (row),
        .o_rd_data (rd_row)
    );

    // unpack the row; a row never written since flush or reset reads as empty
    always_comb begin
        for (int i = 0; i < SLOTS_PER_CLASS; i++) begin
            s_vld[i]   = rd_row[i*SLOT_BITS + 2*WORD_W] & r_row_vld[row];
            s_addr[i]  = rd_row[i*SLOT_BITS + WORD_W +: WORD_W];
            s_words[i] = rd_row[i*SLOT_BITS +: WORD_W];
        end
    end

    // best fit inside each group, lowest slot on ties
    always_comb begin
        for (int g = 0; g < GROUP_COUNT; g++) begin
            g_hit[g]   = 1'b0;
            g_words[g] = '0;
            g_idx[g]   = '0;
            for (int k = 0; k < GROUP_SIZE; k++) begin
                if (g * GROUP_SIZE + k < SLOTS_PER_CLASS) begin
                    if (s_vld[g*GROUP_SIZE+k] && s_words[g*GROUP_SIZE+k] >= r_words &&
                        (!g_hit[g] || s_words[g*GROUP_SIZE+k] < g_words[g])) begin
                        g_hit[g]   = 1'b1;
                        g_words[g] = s_words[g*GROUP_SIZE+k];
                        g_idx[g]   = SLOT_W'(g * GROUP_SIZE + k);
                    end
                end
            end
        end
    end

    // first slot for add or remove
    always_comb begin
        p_hit = 1'b0;
        p_idx = '0;
        for (int i = SLOTS_PER_CLASS - 1; i >= 0; i--) begin
            if (r_mode == MODE_ADD) begin
                if (!s_vld[i] || s_words[i] < r_words) begin
                    p_hit = 1'b1;
                    p_idx = SLOT_W'(i);
                end
            end else begin
                if (s_vld[i] && s_addr[i] == r_addr) begin
                    p_hit = 1'b1;
                    p_idx = SLOT_W'(i);
                end
            end
        end
    end

    // best fit across the groups
    always_comb begin
        f_hit   = 1'b0;
        f_words = '0;
        f_idx   = '0;
        for (int g = 0; g < GROUP_COUNT; g++) begin
            if (r_grp_hit[g] && (!f_hit || r_grp_words[g] < f_words)) begin
                f_hit   = 1'b1;
                f_words = r_grp_words[g];
                f_idx   = r_grp_idx[g];
            end
        end
    end

    // write-back row: free the taken or removed slot, or store the new block
    always_comb begin
        for (int i = 0; i < SLOTS_PER_CLASS; i++) begin
            if (SLOT_W'(i) == r_slot) begin
                if (r_mode == MODE_ADD) begin
                    wr_row[i*SLOT_BITS +: SLOT_BITS] = {1'b1, r_addr, r_words};
                end else begin
                    wr_row[i*SLOT_BITS +: SLOT_BITS] = '0;
                end
            end else begin
                wr_row[i*SLOT_BITS +: SLOT_BITS] = {s_vld[i], s_addr[i], s_words[i]};
            end
        end
    end

    // request, search and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= t_mode'(i_mode);
            r_heap  <= i_heap_select;
            r_addr  <= i_block_addr;
            r_words <= i_block_words;
            r_class <= size_class(i_block_words);
            r_hit   <= 1'b0;
            r_slot  <= '0;
        end
        if (i_cmd.next_class) begin
            r_class <= r_class + CLASS_W'(1);
        end
        if (i_cmd.srch1) begin
            for (int g = 0; g < GROUP_COUNT; g++) begin
                r_grp_hit[g]   <= g_hit[g];
                r_grp_words[g] <= g_words[g];
                r_grp_idx[g]   <= g_idx[g];
            end
            if (r_mode != MODE_GET) begin
                r_hit  <= p_hit;
                r_slot <= p_idx;
            end
        end
        if (i_cmd.srch2 && r_mode == MODE_GET) begin
            r_hit  <= f_hit;
            r_slot <= f_idx;
        end
    end

    // control state: row valid bits, counters, result flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            for (int h = 0; h < HEAP_COUNT; h++) begin
                r_cnt[h] <= '0;
            end
            r_ok     <= 1'b0;
            r_faddr  <= '0;
            r_fwords <= '0;
        end else begin
            if (i_cmd.load) begin
                r_ok     <= 1'b0;
                r_faddr  <= '0;
                r_fwords <= '0;
            end
            if (i_cmd.write) begin
                r_row_vld[row] <= 1'b1;
                r_ok           <= 1'b1;
                if (r_mode == MODE_GET) begin
                    r_faddr        <= s_addr[r_slot];
                    r_fwords       <= s_words[r_slot];
                    r_cnt[r_heap]  <= r_cnt[r_heap] + CNT_W'(1);
                end
            end
            if (i_cmd.flush) begin
                for (int h = 0; h < HEAP_COUNT; h++) begin
                    if (32'(r_heap) == h) begin
                        for (int c = 0; c < CLASS_COUNT; c++) begin
                            r_row_vld[h*CLASS_COUNT + c] <= 1'b0;
                        end
                        r_cnt[h] <= '0;
                    end
                end
                r_ok <= 1'b1;
            end
        end
    end

    // status to the controller
    assign o_status.bad_heap   = !heap_ok;
    assign o_status.flush      = (r_mode == MODE_FLUSH);
    assign o_status.zero_words = (r_mode == MODE_ADD || r_mode == MODE_REMOVE) &&
                                 (r_words == '0);
    assign o_status.is_get     = (r_mode == MODE_GET);
    assign o_status.hit        = r_hit;
    assign o_status.last_class = (32'(r_class) == CLASS_COUNT - 1);

    // result payload
    assign o_ok          = r_ok;
    assign o_found_addr  = r_faddr;
    assign o_found_words = r_fwords;
    assign o_take_count  = heap_ok ? r_cnt[r_heap] : '0;

endmodule

`default_nettype wire

/* design/scfbc_ctrl.sv */
// ----------------------------------------------------------------------------
// scfbc_ctrl
// Controller: sequences decode, row read, search, write-back or flush, and result.
// ----------------------------------------------------------------------------
`default_nettype none

module scfbc_ctrl import scfbc_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_stall,
    output logic         o_valid,
    input  wire logic    i_stall,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_SRCH1,
        S_SRCH2,
        S_EVAL,
        S_WRITE,
        S_FLUSH,
        S_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   r_valid;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.bad_heap || i_status.zero_words) n_state = S_RESULT;
                else if (i_status.flush)                      n_state = S_FLUSH;
                else                                          n_state = S_READ;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_SRCH1;
            end
            S_SRCH1: begin
                o_cmd.srch1 = 1'b1;
                n_state     = S_SRCH2;
            end
            S_SRCH2: begin
                o_cmd.srch2 = 1'b1;
                n_state     = S_EVAL;
            end
            S_EVAL: begin
                if (i_status.hit) begin
                    n_state = S_WRITE;
                end else if (i_status.is_get && !i_status.last_class) begin
                    o_cmd.next_class = 1'b1;
                    n_state          = S_READ;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
                n_state     = S_RESULT;
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = S_RESULT;
            end
            S_RESULT: begin
                if (!i_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered handshake outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
            r_valid <= (n_state == S_RESULT);
        end
    end

    assign o_stall = r_busy;
    assign o_valid = r_valid;

endmodule

`default_nettype wire

/* design/size_class_free_block_cache.sv */
// ----------------------------------------------------------------------------
// size_class_free_block_cache
// Free block cache with 11 size classes per heap and best fit lookup.
// ----------------------------------------------------------------------------
// One operation at a time. The slot table lives in a RAM with one word per
// (heap, class) row of 32 slots, so each class costs one row read and a
// two-step parallel compare. An add or remove writes a slot when it finds
// one, a flush clears the heap's rows, and a request with a bad heap or an
// add or remove of zero words is dropped; a get reads and searches class by
// class from its size class upward until a hit or the last class (up to all
// 11 classes). A further transfer is taken the cycle after the result
// transfer. Flush clears per-row valid bits at once, so there is no clearing
// pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module size_class_free_block_cache import scfbc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [1:0]        i_mode,
    input  wire logic              i_heap_select,
    input  wire logic [WORD_W-1:0] i_block_addr,
    input  wire logic [WORD_W-1:0] i_block_words,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic                   o_ok,
    output logic [WORD_W-1:0]      o_found_addr,
    output logic [WORD_W-1:0]      o_found_words,
    output logic [CNT_W-1:0]       o_take_count
);

    t_cmd    cmd;
    t_status status;

    // sequencer
    scfbc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // table, search and counters
    scfbc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_mode        (i_mode),
        .i_heap_select (i_heap_select),
        .i_block_addr  (i_block_addr),
        .i_block_words (i_block_words),
        .o_ok          (o_ok),
        .o_found_addr  (o_found_addr),
        .o_found_words (o_found_words),
        .o_take_count  (o_take_count)
    );

    // no new transfer is taken while a result is pending
    a_busy_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while result pending");

    // a result that did not succeed carries no block
    a_no_block_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_found_addr == '0 && o_found_words == '0))
        else $error("block reported without success");

    // a result appears only after an accepted transfer
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without a request");

endmodule

`default_nettype wire
